// ----- sv/byte_pattern_search_core_macros.svh -----
// Assertion macros for the byte pattern search checker.
`ifndef BYTE_PATTERN_SEARCH_CORE_MACROS_SVH
`define BYTE_PATTERN_SEARCH_CORE_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define BPS_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define BPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Same-cycle implication that also holds across reset.
`define BPS_ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- sv/bps_pkg.sv -----
// Types, constants and helpers for the byte pattern search core.
package bps_pkg;

   localparam int unsigned MAX_PATTERN    = 16;
   localparam int unsigned WIN_DEPTH      = 16;
   localparam int unsigned WIN_INDEX_BITS = 4;
   localparam int unsigned LEN_BITS       = 5;
   localparam int unsigned OFFSET_BITS    = 32;
   localparam int unsigned OUT_BITS       = 32;
   localparam int unsigned CFG_INDEX_BITS = 2;
   localparam int unsigned CFG_DATA_BITS  = 64;
   localparam int unsigned REQ_DATA_BITS  = 8;
   localparam int unsigned RSP_DATA_BITS  = 2 * OUT_BITS;
   localparam int unsigned PATTERN_BITS   = 8 * MAX_PATTERN;

   typedef logic [7:0]             byte_type;
   typedef logic [OFFSET_BITS-1:0] offset_type;

   typedef enum logic [CFG_INDEX_BITS-1:0] {
      REG_MATCH_MODE     = 2'd0,
      REG_PATTERN_LENGTH = 2'd1,
      REG_PATTERN_LOW    = 2'd2,
      REG_PATTERN_HIGH   = 2'd3
   } reg_index_type;

   localparam logic MODE_TEXT = 1'b0;

   localparam byte_type PRINT_LOW  = 8'h20;
   localparam byte_type PRINT_HIGH = 8'h7E;
   localparam byte_type UPPER_A    = 8'h41;
   localparam byte_type UPPER_Z    = 8'h5A;
   localparam byte_type CASE_DELTA = 8'h20;

   // Packed so that match_offset lands in the low bits of tdata.
   typedef struct packed {
      logic [OUT_BITS-1:0] string_start;
      logic [OUT_BITS-1:0] match_offset;
   } result_type;

   function automatic byte_type fold_case(input byte_type b);
      byte_type r;
      r = b;
      if (b >= UPPER_A && b <= UPPER_Z) begin
         r = b + CASE_DELTA;
      end
      return r;
   endfunction

endpackage

// ----- sv/byte_pattern_search_core.sv -----
// Byte pattern search core: one byte per cycle, every match reported with its offsets.
//
// Accepts one buffer byte per clock cycle without pause as long as results are taken.
// Each byte is compared together with the 15 bytes before it against the whole pattern
// in the cycle it is accepted, so the rate is one byte per cycle; a match is registered in
// the result register, or in the skid buffer while rsp is stalled, before it shows on rsp.
// A result register plus a one-entry skid buffer sit on the response side; req_tready
// drops only when both are full. A request with tlast set is searched normally, then the
// window, offset and printable-run tracking restart at zero. Configuration writes take
// effect on the next byte and do not clear the window.
module byte_pattern_search_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [bps_pkg::CFG_INDEX_BITS-1:0] csr_index,
   input  logic [bps_pkg::CFG_DATA_BITS-1:0]  csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bps_pkg::REQ_DATA_BITS-1:0]  req_tdata,  // [7:0] data_byte
   input  logic                               req_tlast,  // last_byte
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bps_pkg::RSP_DATA_BITS-1:0]  rsp_tdata   // [31:0] match_offset, [63:32] string_start
);
   import bps_pkg::*;

   localparam offset_type OFFSET_MAX = '1;

   logic                      match_mode_ff;
   logic [LEN_BITS-1:0]       pattern_length_ff;
   logic [PATTERN_BITS-1:0]   pattern_ff;

   byte_type                  window_ff  [WIN_DEPTH];
   byte_type                  window_in  [WIN_DEPTH];
   offset_type                history_ff [WIN_DEPTH];
   offset_type                history_in [WIN_DEPTH];
   logic [LEN_BITS-1:0]       fill_ff, fill_in;
   offset_type                offset_ff, offset_in;
   offset_type                run_start_ff, run_start_in;

   logic                      out_valid_ff, skid_valid_ff;
   result_type                out_data_ff, skid_data_ff;

   logic                      accept;
   logic                      drain;
   byte_type                  in_byte;
   logic                      text_mode;
   logic [LEN_BITS-1:0]       eff_len;
   logic [WIN_INDEX_BITS-1:0] len_m1;
   offset_type                offset_inc;
   byte_type                  pattern_bytes [MAX_PATTERN];
   logic [WIN_DEPTH-1:0]      pos_ok;
   logic                      hit;
   result_type                new_result;

   assign in_byte    = req_tdata[7:0];
   assign accept     = req_tvalid && req_tready;
   assign req_tready = !skid_valid_ff;
   assign drain      = !out_valid_ff || rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign text_mode  = (match_mode_ff == MODE_TEXT);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         match_mode_ff     <= 1'b0;
         pattern_length_ff <= LEN_BITS'(1);
         pattern_ff        <= '0;
      end else if (csr_wr_en) begin
         unique case (reg_index_type'(csr_index))
            REG_MATCH_MODE:     match_mode_ff     <= csr_wdata[0];
            REG_PATTERN_LENGTH: pattern_length_ff <= csr_wdata[LEN_BITS-1:0];
            REG_PATTERN_LOW:    pattern_ff[CFG_DATA_BITS-1:0] <= csr_wdata;
            REG_PATTERN_HIGH:   pattern_ff[PATTERN_BITS-1:CFG_DATA_BITS] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (pattern_length_ff == '0) begin
         eff_len = LEN_BITS'(1);
      end else if (pattern_length_ff > LEN_BITS'(MAX_PATTERN)) begin
         eff_len = LEN_BITS'(MAX_PATTERN);
      end else begin
         eff_len = pattern_length_ff;
      end
   end

   assign len_m1     = WIN_INDEX_BITS'(eff_len - LEN_BITS'(1));
   assign offset_inc = (offset_ff == OFFSET_MAX) ? OFFSET_MAX : offset_ff + OFFSET_BITS'(1);

   always_comb begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         pattern_bytes[k] = pattern_ff[8*k +: 8];
      end
   end

   // shifted window and run-start history, newest at entry 0
   always_comb begin
      if (in_byte < PRINT_LOW || in_byte > PRINT_HIGH) begin
         run_start_in = offset_inc;
      end else begin
         run_start_in = run_start_ff;
      end
      window_in[0]  = in_byte;
      history_in[0] = run_start_in;
      for (int i = 1; i < WIN_DEPTH; i++) begin
         window_in[i]  = window_ff[i-1];
         history_in[i] = history_ff[i-1];
      end
      fill_in   = (fill_ff == LEN_BITS'(WIN_DEPTH)) ? fill_ff : fill_ff + LEN_BITS'(1);
      offset_in = offset_inc;
   end

   // window entry j lines up with pattern byte len-1-j
   always_comb begin
      logic [WIN_INDEX_BITS-1:0] pidx;
      byte_type                  d, p;
      for (int j = 0; j < WIN_DEPTH; j++) begin
         pidx = len_m1 - WIN_INDEX_BITS'(j);
         d    = window_in[j];
         p    = pattern_bytes[pidx];
         if (text_mode) begin
            d = fold_case(d);
            p = fold_case(p);
         end
         pos_ok[j] = (WIN_INDEX_BITS'(j) > len_m1) || (d == p);
      end
      hit = (fill_in >= eff_len) && (&pos_ok);
   end

   always_comb begin
      offset_type start;
      start = offset_ff - OFFSET_BITS'(len_m1);
      new_result.match_offset = start[OUT_BITS-1:0];
      new_result.string_start = text_mode ? history_in[len_m1][OUT_BITS-1:0] : '0;
   end

   // window payload; entries beyond the fill count are never compared
   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff  <= window_in;
         history_ff <= history_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         offset_ff    <= '0;
         run_start_ff <= '0;
      end else if (accept) begin
         if (req_tlast) begin
            fill_ff      <= '0;
            offset_ff    <= '0;
            run_start_ff <= '0;
         end else begin
            fill_ff      <= fill_in;
            offset_ff    <= offset_in;
            run_start_ff <= run_start_in;
         end
      end
   end

   // result register with skid buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (drain) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= accept && hit;
         end
      end else if (accept && hit) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (drain) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : new_result;
      end
      if (!drain && accept && hit) begin
         skid_data_ff <= new_result;
      end
   end

endmodule

// ----- sv/bps_checker.sv -----
// Port-level assertions for the byte pattern search core, bound to the top level.
`include "byte_pattern_search_core_macros.svh"

module bps_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [bps_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import bps_pkg::*;

   `BPS_ASSERT_NEXT(a_rsp_valid_held, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp_tvalid dropped while stalled")
   `BPS_ASSERT_NEXT(a_rsp_data_held, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "rsp_tdata changed while stalled")
   `BPS_ASSERT_IMPLY(a_stall_needs_rsp, !req_tready, rsp_tvalid, "request stalled with no response pending")
   `BPS_ASSERT_ALWAYS(a_reset_empties, $past(reset) && !reset, !rsp_tvalid, "response valid right after reset")

endmodule

bind byte_pattern_search_core bps_checker u_bps_checker (.*);
